// ----- rtl/mtse_pkg.sv -----
// shared constants, types and command codes of the mt19937 state engine
`default_nettype none

package mtse_pkg;

	// state array geometry
	localparam int STATE_WORDS  = 624;
	localparam int SHIFT_OFFSET = 397;
	localparam int STATE_AW     = $clog2(STATE_WORDS);
	localparam int RIDX_W       = $clog2(STATE_WORDS + 2);

	// key buffer geometry
	localparam int KEY_WORDS = 128;
	localparam int KEY_AW    = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int KEY_CW    = $clog2(KEY_WORDS + 1);
	localparam int KEY_SW    = ((KEY_CW > KEY_AW) ? KEY_CW : KEY_AW) + 1;

	// field widths
	localparam int WORD_W = 32;
	localparam int CMD_W  = 2;

	// request command codes
	localparam logic [CMD_W-1:0] CMD_SEED = 2'd0;
	localparam logic [CMD_W-1:0] CMD_KEY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DRAW = 2'd2;

	// recurrence constants
	localparam logic [WORD_W-1:0] TW_MATRIX    = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] TW_UPPER     = 32'h8000_0000;
	localparam logic [WORD_W-1:0] TW_LOWER     = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] LCG_MULT     = 32'd1812433253;
	localparam logic [WORD_W-1:0] MIX1_MULT    = 32'd1664525;
	localparam logic [WORD_W-1:0] MIX2_MULT    = 32'd1566083941;
	localparam logic [WORD_W-1:0] ARRAY_SEED   = 32'd19650218;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

	// read index special values
	localparam logic [RIDX_W-1:0] RIDX_EMPTY    = RIDX_W'(STATE_WORDS);
	localparam logic [RIDX_W-1:0] RIDX_UNSEEDED = RIDX_W'(STATE_WORDS + 1);

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		DP_NOP,
		DP_KEY_PUSH,
		DP_LCG_START,
		DP_LCG_MUL,
		DP_LCG_WR,
		DP_MIX_START,
		DP_M1_RD,
		DP_M1_WR,
		DP_M2_RD,
		DP_M2_WR,
		DP_MIX_END,
		DP_RG_FIRST,
		DP_RG_LOAD0,
		DP_RG_RDN,
		DP_RG_RDS,
		DP_RG_WR,
		DP_DRAW_RD,
		DP_DRAW_OUT
	} dp_op_t;

	typedef enum logic [1:0] {
		SS_VALUE,
		SS_ARRAY,
		SS_DEFAULT
	} seed_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LCG_INIT,
		ST_LCG_MUL,
		ST_LCG_WR,
		ST_MIX_INIT,
		ST_M1_RD,
		ST_M1_WR,
		ST_M2_RD,
		ST_M2_WR,
		ST_MIX_END,
		ST_RG_FIRST,
		ST_RG_LOAD0,
		ST_RG_RDN,
		ST_RG_RDS,
		ST_RG_WR,
		ST_DRAW_RD,
		ST_DRAW_OUT
	} state_t;

	typedef struct packed {
		logic      cap;
		dp_op_t    op;
		seed_sel_t seed_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic idx_last;
		logic step_last;
		logic ridx_unseeded;
		logic ridx_empty;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/mt19937_state_engine.sv -----
// mt19937 state engine: 624-word twister state with seeding, array init and raw draws
//
// Requests enter on in_valid/in_stall with cmd, value and last; cmd 0 seeds from
// value, cmd 1 pushes a key word (last starts the array initialisation), cmd 2
// draws the next untempered state word, cmd 3 is dropped. Only draws give a
// result, on out_valid/out_stall with word. Requests are taken one at a time:
// in_stall stays high until the current one has finished.
// Work per request: a draw from a fresh state word reads it into the result register;
// a draw needing a twist first regenerates every state word in place (read next,
// read shifted, write back); a seed, or the implied default seed on a first draw,
// fills every word from the one before; an array initialisation is a seed fill
// followed by the two mixing passes over the key.
// A finished result waits in the output register while the next request is
// taken; a draw whose result slot is still held by a stalled receiver waits
// until that result has been taken. Reset leaves the block unseeded with an
// empty key buffer; the state memory is not cleared.
`default_nettype none

module mt19937_state_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mtse_pkg::CMD_W-1:0]        cmd,
	input  logic [mtse_pkg::WORD_W-1:0]       value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [mtse_pkg::WORD_W-1:0]       word
);

	import mtse_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	mtse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status)
	);

	mtse_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.word      (word)
	);

	// a draw never reads past the last fresh state word
	assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == DP_DRAW_RD |-> !dp_status.ridx_empty)
		else $error("draw read with exhausted state");

	// a new result never overwrites one still held by the receiver
	assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == DP_DRAW_OUT |-> (!out_valid || !out_stall))
		else $error("result register overwritten");

	// the end of a twist leaves the state fresh
	assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == DP_RG_WR && dp_status.idx_last) |=> !dp_status.ridx_empty)
		else $error("twist did not refresh read index");

	// the end of a seed fill marks the block seeded and due for a twist
	assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.op == DP_LCG_WR && dp_status.idx_last)
		|=> (dp_status.ridx_empty && !dp_status.ridx_unseeded))
		else $error("seed fill left wrong read index");

endmodule

`default_nettype wire

// ----- rtl/mtse_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module mtse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/mtse_ctrl.sv -----
// sequencing controller: request handshake, seeding, mixing, twist and draw steps
`default_nettype none

module mtse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           cmd,
	input  logic                 last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mtse_pkg::dp_cmd_t    dp_cmd,
	input  mtse_pkg::dp_status_t dp_status
);

	import mtse_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CMD_W-1:0] cmd_q;
	logic             last_q;
	logic             out_valid_q;
	logic             in_acc;
	logic             out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// state and captured request control fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= CMD_SEED;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cmd_q  <= cmd;
				last_q <= last;
			end
			if (dp_cmd.op == DP_DRAW_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (cmd_q)
					CMD_SEED: state_d = ST_LCG_INIT;
					CMD_KEY:  state_d = last_q ? ST_LCG_INIT : ST_IDLE;
					CMD_DRAW: begin
						if (dp_status.ridx_unseeded) begin
							state_d = ST_LCG_INIT;
						end else if (dp_status.ridx_empty) begin
							state_d = ST_RG_FIRST;
						end else begin
							state_d = ST_DRAW_RD;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_LCG_INIT: state_d = ST_LCG_MUL;
			ST_LCG_MUL:  state_d = ST_LCG_WR;
			ST_LCG_WR: begin
				if (!dp_status.idx_last) begin
					state_d = ST_LCG_MUL;
				end else begin
					case (cmd_q)
						CMD_KEY:  state_d = ST_MIX_INIT;
						CMD_DRAW: state_d = ST_RG_FIRST;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_MIX_INIT: state_d = ST_M1_RD;
			ST_M1_RD:    state_d = ST_M1_WR;
			ST_M1_WR:    state_d = dp_status.step_last ? ST_M2_RD : ST_M1_RD;
			ST_M2_RD:    state_d = ST_M2_WR;
			ST_M2_WR:    state_d = dp_status.step_last ? ST_MIX_END : ST_M2_RD;
			ST_MIX_END:  state_d = ST_IDLE;
			ST_RG_FIRST: state_d = ST_RG_LOAD0;
			ST_RG_LOAD0: state_d = ST_RG_RDS;
			ST_RG_RDN:   state_d = ST_RG_RDS;
			ST_RG_RDS:   state_d = ST_RG_WR;
			ST_RG_WR:    state_d = dp_status.idx_last ? ST_DRAW_RD : ST_RG_RDN;
			ST_DRAW_RD:  state_d = ST_DRAW_OUT;
			ST_DRAW_OUT: state_d = out_free ? ST_IDLE : ST_DRAW_OUT;
			default:     state_d = ST_IDLE;
		endcase
	end

	// datapath command
	always_comb begin
		dp_cmd.cap = in_acc;
		case (cmd_q)
			CMD_SEED: dp_cmd.seed_sel = SS_VALUE;
			CMD_KEY:  dp_cmd.seed_sel = SS_ARRAY;
			default:  dp_cmd.seed_sel = SS_DEFAULT;
		endcase
		case (state_q)
			ST_DISPATCH: dp_cmd.op = (cmd_q == CMD_KEY) ? DP_KEY_PUSH : DP_NOP;
			ST_LCG_INIT: dp_cmd.op = DP_LCG_START;
			ST_LCG_MUL:  dp_cmd.op = DP_LCG_MUL;
			ST_LCG_WR:   dp_cmd.op = DP_LCG_WR;
			ST_MIX_INIT: dp_cmd.op = DP_MIX_START;
			ST_M1_RD:    dp_cmd.op = DP_M1_RD;
			ST_M1_WR:    dp_cmd.op = DP_M1_WR;
			ST_M2_RD:    dp_cmd.op = DP_M2_RD;
			ST_M2_WR:    dp_cmd.op = DP_M2_WR;
			ST_MIX_END:  dp_cmd.op = DP_MIX_END;
			ST_RG_FIRST: dp_cmd.op = DP_RG_FIRST;
			ST_RG_LOAD0: dp_cmd.op = DP_RG_LOAD0;
			ST_RG_RDN:   dp_cmd.op = DP_RG_RDN;
			ST_RG_RDS:   dp_cmd.op = DP_RG_RDS;
			ST_RG_WR:    dp_cmd.op = DP_RG_WR;
			ST_DRAW_RD:  dp_cmd.op = DP_DRAW_RD;
			ST_DRAW_OUT: dp_cmd.op = out_free ? DP_DRAW_OUT : DP_NOP;
			default:     dp_cmd.op = DP_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/mtse_dpath.sv -----
// datapath: state and key memories, shared multiplier, counters and result register
`default_nettype none

module mtse_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [mtse_pkg::WORD_W-1:0]    value,
	input  mtse_pkg::dp_cmd_t              dp_cmd,
	output mtse_pkg::dp_status_t           dp_status,
	output logic [mtse_pkg::WORD_W-1:0]    word
);

	import mtse_pkg::*;

	// request payload and working words
	logic [WORD_W-1:0] value_q;
	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] mul_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] nxt_q;
	logic [WORD_W-1:0] word_q;

	// counters
	logic [STATE_AW-1:0] i_q;
	logic [STATE_AW-1:0] k_q;
	logic [KEY_AW-1:0]   j_q;
	logic [KEY_CW-1:0]   key_count_q;
	logic [RIDX_W-1:0]   ridx_q;

	// memory ports
	logic                st_we;
	logic [STATE_AW-1:0] st_waddr;
	logic [WORD_W-1:0]   st_wdata;
	logic                st_re;
	logic [STATE_AW-1:0] st_raddr;
	logic [WORD_W-1:0]   st_rdata;
	logic                key_we;
	logic                key_re;
	logic [WORD_W-1:0]   key_rdata;

	// derived values
	logic [WORD_W-1:0]   seed;
	logic [WORD_W-1:0]   mul_k;
	logic [WORD_W-1:0]   mix_f;
	logic [WORD_W-1:0]   lcg_w;
	logic [WORD_W-1:0]   mix1_w;
	logic [WORD_W-1:0]   mix2_w;
	logic [WORD_W-1:0]   y;
	logic [WORD_W-1:0]   rg_w;
	logic [STATE_AW-1:0] i_wrap;
	logic [STATE_AW-1:0] nx_addr;
	logic [STATE_AW-1:0] src_addr;
	logic [STATE_AW-1:0] k_init;
	logic [STATE_AW-1:0] len_ext;
	logic                j_wrap;
	logic                key_room;

	localparam logic [STATE_AW-1:0] IDX_LAST = STATE_AW'(STATE_WORDS - 1);
	localparam logic [STATE_AW-1:0] SRC_SPLIT = STATE_AW'(STATE_WORDS - SHIFT_OFFSET);

	// seed and multiplier constant selection
	always_comb begin
		case (dp_cmd.seed_sel)
			SS_VALUE: seed = value_q;
			SS_ARRAY: seed = ARRAY_SEED;
			default:  seed = DEFAULT_SEED;
		endcase
		case (dp_cmd.op)
			DP_M1_RD: mul_k = MIX1_MULT;
			DP_M2_RD: mul_k = MIX2_MULT;
			default:  mul_k = LCG_MULT;
		endcase
	end

	// word recurrences
	assign mix_f  = prev_q ^ (prev_q >> 30);
	assign lcg_w  = mul_q + WORD_W'(i_q);
	assign mix1_w = (st_rdata ^ mul_q) + key_rdata + WORD_W'(j_q);
	assign mix2_w = (st_rdata ^ mul_q) - WORD_W'(i_q);
	assign y      = (cur_q & TW_UPPER) | (nxt_q & TW_LOWER);
	assign rg_w   = st_rdata ^ (y >> 1) ^ (y[0] ? TW_MATRIX : '0);

	// index arithmetic
	assign i_wrap   = (i_q == IDX_LAST) ? STATE_AW'(1) : i_q + STATE_AW'(1);
	assign nx_addr  = (i_q == IDX_LAST) ? '0 : i_q + STATE_AW'(1);
	assign src_addr = (i_q < SRC_SPLIT) ? i_q + STATE_AW'(SHIFT_OFFSET) : i_q - SRC_SPLIT;
	assign len_ext  = STATE_AW'(key_count_q);
	assign k_init   = (len_ext > STATE_AW'(STATE_WORDS)) ? len_ext : STATE_AW'(STATE_WORDS);
	assign j_wrap   = (KEY_SW'(j_q) + KEY_SW'(1)) >= KEY_SW'(key_count_q);
	assign key_room = key_count_q < KEY_CW'(KEY_WORDS);

	// state and key memory port selection
	always_comb begin
		st_we    = 1'b0;
		st_waddr = i_q;
		st_wdata = lcg_w;
		st_re    = 1'b0;
		st_raddr = i_q;
		key_we   = 1'b0;
		key_re   = 1'b0;
		case (dp_cmd.op)
			DP_KEY_PUSH: key_we = key_room;
			DP_LCG_START: begin
				st_we    = 1'b1;
				st_waddr = '0;
				st_wdata = seed;
			end
			DP_LCG_WR: st_we = 1'b1;
			DP_M1_RD: begin
				st_re  = 1'b1;
				key_re = 1'b1;
			end
			DP_M1_WR: begin
				st_we    = 1'b1;
				st_wdata = mix1_w;
			end
			DP_M2_RD: st_re = 1'b1;
			DP_M2_WR: begin
				st_we    = 1'b1;
				st_wdata = mix2_w;
			end
			DP_MIX_END: begin
				st_we    = 1'b1;
				st_waddr = '0;
				st_wdata = TW_UPPER;
			end
			DP_RG_FIRST: begin
				st_re    = 1'b1;
				st_raddr = '0;
			end
			DP_RG_LOAD0, DP_RG_RDN: begin
				st_re    = 1'b1;
				st_raddr = nx_addr;
			end
			DP_RG_RDS: begin
				st_re    = 1'b1;
				st_raddr = src_addr;
			end
			DP_RG_WR: begin
				st_we    = 1'b1;
				st_wdata = rg_w;
			end
			DP_DRAW_RD: begin
				st_re    = 1'b1;
				st_raddr = STATE_AW'(ridx_q);
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	// counters and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			key_count_q <= '0;
			ridx_q      <= RIDX_UNSEEDED;
		end else begin
			case (dp_cmd.op)
				DP_KEY_PUSH: begin
					if (key_room) begin
						key_count_q <= key_count_q + KEY_CW'(1);
					end
				end
				DP_LCG_START: i_q <= STATE_AW'(1);
				DP_LCG_WR: begin
					i_q <= i_q + STATE_AW'(1);
					if (i_q == IDX_LAST) begin
						ridx_q <= RIDX_EMPTY;
					end
				end
				DP_MIX_START: begin
					i_q <= STATE_AW'(1);
					j_q <= '0;
					k_q <= k_init;
				end
				DP_M1_WR: begin
					i_q <= i_wrap;
					j_q <= j_wrap ? '0 : j_q + KEY_AW'(1);
					k_q <= (k_q == STATE_AW'(1)) ? IDX_LAST : k_q - STATE_AW'(1);
				end
				DP_M2_WR: begin
					i_q <= i_wrap;
					k_q <= k_q - STATE_AW'(1);
				end
				DP_MIX_END: begin
					key_count_q <= '0;
					ridx_q      <= RIDX_EMPTY;
				end
				DP_RG_FIRST: i_q <= '0;
				DP_RG_WR: begin
					i_q <= i_q + STATE_AW'(1);
					if (i_q == IDX_LAST) begin
						ridx_q <= '0;
					end
				end
				DP_DRAW_RD: ridx_q <= ridx_q + RIDX_W'(1);
				default: begin
					ridx_q <= ridx_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (dp_cmd.cap) begin
			value_q <= value;
		end
		case (dp_cmd.op)
			DP_LCG_START: prev_q <= seed;
			DP_LCG_MUL:   mul_q  <= mul_k * mix_f;
			DP_LCG_WR:    prev_q <= lcg_w;
			// first mixing step works from word 0, the array seed
			DP_MIX_START: prev_q <= seed;
			DP_M1_RD:     mul_q  <= mul_k * mix_f;
			DP_M1_WR:     prev_q <= mix1_w;
			DP_M2_RD:     mul_q  <= mul_k * mix_f;
			DP_M2_WR:     prev_q <= mix2_w;
			DP_RG_LOAD0:  cur_q  <= st_rdata;
			DP_RG_RDS:    nxt_q  <= st_rdata;
			DP_RG_WR:     cur_q  <= nxt_q;
			DP_DRAW_OUT:  word_q <= st_rdata;
			default: begin
				word_q <= word_q;
			end
		endcase
	end

	// status to the controller
	assign dp_status.idx_last      = (i_q == IDX_LAST);
	assign dp_status.step_last     = (k_q == STATE_AW'(1));
	assign dp_status.ridx_unseeded = (ridx_q == RIDX_UNSEEDED);
	assign dp_status.ridx_empty    = (ridx_q >= RIDX_EMPTY);
	assign word = word_q;

	mtse_ram #(
		.WIDTH (WORD_W),
		.DEPTH (STATE_WORDS)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	mtse_ram #(
		.WIDTH (WORD_W),
		.DEPTH (KEY_WORDS)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (KEY_AW'(key_count_q)),
		.wdata (value_q),
		.re    (key_re),
		.raddr (j_q),
		.rdata (key_rdata)
	);

endmodule

`default_nettype wire

// ----- sim/mt19937_state_engine_checker.sv -----
// checker for the mt19937 state engine: tracks the twister state and compares every drawn word
`default_nettype none

module mt19937_state_engine_checker
	import mtse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [WORD_W-1:0] value,
	input  logic              last,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [WORD_W-1:0] word,
	output int                failures,
	output int                words_owed
);

	localparam int REPORT_LIMIT = 10;

	// own copy of the generator state
	logic [WORD_W-1:0] twist_words [STATE_WORDS];
	logic [WORD_W-1:0] key_words [KEY_WORDS];
	int unsigned       key_len;
	int unsigned       draw_pos;

	// words owed for draws taken but not yet delivered
	logic [WORD_W-1:0] expected_words [$];
	logic [WORD_W-1:0] wanted_word;
	int                mismatch_total = 0;
	int                words_seen = 0;

	// linear-congruential fill from one seed
	function automatic void seed_fill(input logic [WORD_W-1:0] seed);
		logic [WORD_W-1:0] p;
		twist_words[0] = seed;
		for (int n = 1; n < STATE_WORDS; n++) begin
			p = twist_words[n - 1];
			twist_words[n] = LCG_MULT * (p ^ (p >> 30)) + WORD_W'(n);
		end
		draw_pos = STATE_WORDS;
	endfunction

	// init by array over the collected key words
	function automatic void mix_keys(input int unsigned len);
		logic [WORD_W-1:0] p;
		int unsigned       i;
		int unsigned       j;
		int unsigned       steps;
		seed_fill(ARRAY_SEED);
		i = 1;
		j = 0;
		steps = (STATE_WORDS > len) ? STATE_WORDS : len;
		// first pass folds in the key
		repeat (steps) begin
			p = twist_words[i - 1];
			twist_words[i] = (twist_words[i] ^ ((p ^ (p >> 30)) * MIX1_MULT))
				+ key_words[j % KEY_WORDS] + WORD_W'(j);
			i++;
			j++;
			if (i >= STATE_WORDS) begin
				twist_words[0] = twist_words[STATE_WORDS - 1];
				i = 1;
			end
			if (j >= len)
				j = 0;
		end
		// second pass subtracts the position
		repeat (STATE_WORDS - 1) begin
			p = twist_words[i - 1];
			twist_words[i] = (twist_words[i] ^ ((p ^ (p >> 30)) * MIX2_MULT)) - WORD_W'(i);
			i++;
			if (i >= STATE_WORDS) begin
				twist_words[0] = twist_words[STATE_WORDS - 1];
				i = 1;
			end
		end
		twist_words[0] = 32'h8000_0000;
	endfunction

	// in-place regeneration of the whole state
	function automatic void twist_all();
		logic [WORD_W-1:0] y;
		for (int n = 0; n < STATE_WORDS; n++) begin
			y = (twist_words[n] & TW_UPPER) | (twist_words[(n + 1) % STATE_WORDS] & TW_LOWER);
			twist_words[n] = twist_words[(n + SHIFT_OFFSET) % STATE_WORDS] ^ (y >> 1)
				^ (y[0] ? TW_MATRIX : WORD_W'(0));
		end
		draw_pos = 0;
	endfunction

	// next raw word, regenerating (and default seeding) as needed
	function automatic logic [WORD_W-1:0] next_draw();
		logic [WORD_W-1:0] w;
		if (draw_pos >= STATE_WORDS) begin
			if (draw_pos == STATE_WORDS + 1)
				seed_fill(DEFAULT_SEED);
			twist_all();
		end
		w = twist_words[draw_pos % STATE_WORDS];
		draw_pos++;
		return w;
	endfunction

	// effect of one accepted request
	function automatic void apply_request(input logic [CMD_W-1:0] op,
			input logic [WORD_W-1:0] data, input logic fin);
		case (op)
			CMD_SEED: begin
				seed_fill(data);
			end
			CMD_KEY: begin
				// words past the buffer are dropped, the last mark still counts
				if (key_len < KEY_WORDS) begin
					key_words[key_len] = data;
					key_len++;
				end
				if (fin) begin
					mix_keys(key_len);
					key_len = 0;
				end
			end
			CMD_DRAW: begin
				expected_words.push_back(next_draw());
			end
			default: begin
				// unused code changes nothing
			end
		endcase
	endfunction

	// compare results first, then predict from the request taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len = 0;
			draw_pos = STATE_WORDS + 1;
			expected_words.delete();
			failures <= mismatch_total;
			words_owed <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					mismatch_total++;
					if (mismatch_total <= REPORT_LIMIT)
						$display("%0t: word %h delivered with no draw outstanding", $time, word);
				end else begin
					wanted_word = expected_words.pop_front();
					if (word !== wanted_word) begin
						mismatch_total++;
						if (mismatch_total <= REPORT_LIMIT)
							$display("%0t: draw %0d word expected %h actual %h",
								$time, words_seen, wanted_word, word);
					end
				end
				words_seen++;
			end
			if (in_valid && !in_stall)
				apply_request(cmd, value, last);
			failures <= mismatch_total;
			words_owed <= expected_words.size();
		end
	end

endmodule

`default_nettype wire

// ----- sim/tb_mt19937_state_engine.sv -----
// testbench top for the mt19937 state engine: stimulus, handshake idling and verdict
`default_nettype none

module tb_mt19937_state_engine;

	import mtse_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEM_TARGET   = 1100;
	localparam int SETTLE_CYCLES = 5000;
	localparam int CYCLE_LIMIT   = 20_000_000;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd;
	logic [WORD_W-1:0] value;
	logic              last;
	logic              out_valid;
	logic              out_stall;
	logic [WORD_W-1:0] word;

	int   fail_count;
	int   words_owed;
	int   requests_sent = 0;
	int   cycle_count = 0;
	int   pick;
	logic calm;

	// no idling on either side while this window of requests goes through
	assign calm = (requests_sent >= 350) && (requests_sent < 650);

	mt19937_state_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.word      (word)
	);

	mt19937_state_engine_checker word_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.value      (value),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.word       (word),
		.failures   (fail_count),
		.words_owed (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// count accepted requests
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			requests_sent <= requests_sent + 1;
	end

	// receiver stalls at random outside the calm window
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 17);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_mt19937_state_engine failed");
			$finish;
		end
	end

	// mostly random words, sometimes the extremes
	function automatic logic [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// one request, with a random gap in front of it
	task automatic send_request(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] data,
			input logic fin);
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			cmd      <= CMD_W'($urandom);
			value    <= $urandom;
			last     <= 1'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		value    <= data;
		last     <= fin;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// key collection, now and then interrupted by a seed or a draw
	task automatic send_keys(input int count, input bit finish);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 19) == 0)
				send_request(($urandom_range(0, 1) != 0) ? CMD_SEED : CMD_DRAW, pick_value(),
					1'($urandom));
			send_request(CMD_KEY, pick_value(), finish && (n == count - 1));
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= CMD_SEED;
		value     <= '0;
		last      <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default seed on first draw, seed extremes, unused code,
		// short keys, seed and draw inside a collection
		send_request(CMD_DRAW, 32'hffff_ffff, 1'b1);
		send_request(CMD_DRAW, 32'h0000_0000, 1'b0);
		send_request(CMD_SEED, 32'h0000_0000, 1'b1);
		send_request(CMD_DRAW, 32'h0000_0000, 1'b0);
		send_request(CMD_SEED, 32'hffff_ffff, 1'b0);
		send_request(CMD_DRAW, 32'hffff_ffff, 1'b0);
		send_request(CMD_UNUSED, 32'hffff_ffff, 1'b1);
		send_request(CMD_DRAW, 32'h1234_5678, 1'b1);
		send_request(CMD_KEY, 32'h0000_0000, 1'b1);
		send_request(CMD_DRAW, 32'h0000_0000, 1'b0);
		send_request(CMD_KEY, 32'hffff_ffff, 1'b0);
		send_request(CMD_SEED, 32'h8000_0000, 1'b0);
		send_request(CMD_DRAW, 32'h0000_0000, 1'b0);
		send_request(CMD_KEY, 32'h5a5a_5a5a, 1'b1);
		send_request(CMD_DRAW, 32'h0000_0000, 1'b0);
		send_request(CMD_UNUSED, 32'h0000_0000, 1'b0);
		send_request(CMD_DRAW, 32'h0000_0000, 1'b0);
		send_request(CMD_SEED, 32'd5489, 1'b0);
		send_request(CMD_DRAW, 32'h0000_0000, 1'b0);
		send_request(CMD_KEY, 32'ha5a5_a5a5, 1'b1);
		send_request(CMD_DRAW, 32'h0000_0000, 1'b0);

		// long draw run across a regeneration boundary
		repeat ($urandom_range(630, 700))
			send_request(CMD_DRAW, $urandom, 1'($urandom));

		// overflowing collection, last mark on a dropped word
		send_keys($urandom_range(KEY_WORDS + 1, KEY_WORDS + 12), 1'b1);

		// random mix of draw bursts, key collections, seeds and noise
		while (requests_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				repeat ($urandom_range(1, 30))
					send_request(CMD_DRAW, $urandom, 1'($urandom));
			end else if (pick < 65) begin
				send_keys(($urandom_range(0, 7) == 0) ?
					$urandom_range(KEY_WORDS - 8, KEY_WORDS + 8) : $urandom_range(1, 6),
					$urandom_range(0, 9) != 0);
			end else if (pick < 77) begin
				send_request(CMD_SEED, pick_value(), 1'($urandom));
			end else if (pick < 83) begin
				send_request(CMD_UNUSED, $urandom, 1'($urandom));
			end else if (pick < 90) begin
				send_request(CMD_KEY, pick_value(), 1'b0);
			end else begin
				repeat ($urandom_range(1, 5))
					send_request(CMD_DRAW, $urandom, 1'($urandom));
			end
		end
		in_valid <= 1'b0;

		// drain owed words, then watch for stray results
		while (words_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_mt19937_state_engine passed");
		else
			$display("tb_mt19937_state_engine failed");
		$finish;
	end

endmodule

`default_nettype wire
